>>> design/w2r_pkg.sv
// shared types, band table and per-band constants for the wavelength to rgb unit
`timescale 1ns / 1ps
`default_nettype none

package w2r_pkg;

    localparam int WL_W    = 14;   // wavelength, 4 fraction bits
    localparam int OUT_W   = 12;   // channel intensity, 12 fraction bits
    localparam int NCHAN   = 3;
    localparam int NBANDS  = 10;
    localparam int BAND_W  = 4;
    localparam int D_W     = 11;   // offset into a band, sixteenths of a nm
    localparam int CHAN_W  = 2;

    localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;
    localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;

    localparam logic [OUT_W-1:0] OUT_MAX = 12'hFFF;

    // one spectral band: range, origin of t, width and coefficients in hundredths
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [9:0]        lo_nm;
        logic [9:0]        hi_nm;
        logic [9:0]        base_nm;
        logic [6:0]        width_nm;
        logic signed [8:0] c0;
        logic signed [8:0] c1;
        logic signed [8:0] c2;
    } band_t;

    // bands in priority order, first match per channel wins
    localparam band_t BANDS [NBANDS] = '{
        '{CH_RED,   10'd400, 10'd410, 10'd400, 7'd10,   9'sd0,   9'sd33,  -9'sd20},
        '{CH_RED,   10'd410, 10'd475, 10'd410, 7'd65,   9'sd14,  9'sd0,   -9'sd13},
        '{CH_RED,   10'd545, 10'd595, 10'd545, 7'd50,   9'sd0,   9'sd198, -9'sd100},
        '{CH_RED,   10'd595, 10'd650, 10'd595, 7'd55,   9'sd98,  9'sd6,   -9'sd40},
        '{CH_RED,   10'd650, 10'd700, 10'd650, 7'd50,   9'sd65,  -9'sd84, 9'sd20},
        '{CH_GREEN, 10'd415, 10'd475, 10'd415, 7'd60,   9'sd0,   9'sd0,   9'sd80},
        '{CH_GREEN, 10'd475, 10'd590, 10'd475, 7'd115,  9'sd80,  9'sd76,  -9'sd80},
        '{CH_GREEN, 10'd590, 10'd639, 10'd585, 7'd54,   9'sd84,  -9'sd84, 9'sd0},
        '{CH_BLUE,  10'd400, 10'd475, 10'd400, 7'd75,   9'sd0,   9'sd220, -9'sd150},
        '{CH_BLUE,  10'd475, 10'd560, 10'd475, 7'd85,   9'sd70,  -9'sd100, 9'sd30}
    };

    // floor(2^36 / (50 * width^2)) per band
    localparam logic [23:0] RECIP [NBANDS] = '{
        24'd13743895, 24'd325299, 24'd549755, 24'd454343, 24'd549755,
        24'd381774,   24'd103923, 24'd471327, 24'd244335, 24'd190226
    };

    // per-channel band select result
    typedef struct packed {
        logic              hit;
        logic [BAND_W-1:0] band;
        logic [D_W-1:0]    d;
    } lane_in_t;

    // load strobes of the pipeline registers, stage 1 to the output register
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
        logic ld6;
        logic ld7;
    } pipe_ld_t;

    function automatic band_t band_of(input logic [BAND_W-1:0] b);
        band_t r;
        r = '0;
        if (b < BAND_W'(NBANDS)) begin
            r = BANDS[b];
        end
        return r;
    endfunction

    function automatic logic [23:0] band_recip(input logic [BAND_W-1:0] b);
        logic [23:0] r;
        r = '0;
        if (b < BAND_W'(NBANDS)) begin
            r = RECIP[b];
        end
        return r;
    endfunction

    function automatic logic [13:0] band_wsq(input logic [BAND_W-1:0] b);
        band_t bd;
        bd = band_of(b);
        return 14'(bd.width_nm) * 14'(bd.width_nm);
    endfunction

    // c0 * W^2 with W = 16 * width
    function automatic logic signed [32:0] band_k0(input logic [BAND_W-1:0] b);
        band_t bd;
        logic [13:0] wsq;
        bd  = band_of(b);
        wsq = band_wsq(b);
        return 33'(bd.c0) * $signed({11'b0, wsq, 8'b0});
    endfunction

    // c1 * W
    function automatic logic signed [19:0] band_k1(input logic [BAND_W-1:0] b);
        band_t bd;
        bd = band_of(b);
        return 20'(bd.c1) * $signed({9'b0, bd.width_nm, 4'b0});
    endfunction

    // rounding offset, 25 * width^2
    function automatic logic [18:0] band_k25(input logic [BAND_W-1:0] b);
        return 19'(band_wsq(b)) * 19'd25;
    endfunction

    // divisor, 50 * width^2
    function automatic logic [19:0] band_den(input logic [BAND_W-1:0] b);
        return 20'(band_wsq(b)) * 20'd50;
    endfunction

endpackage

`default_nettype wire

>>> design/w2r_band_sel.sv
// first pipeline stage: band lookup per channel and offset into the band
`timescale 1ns / 1ps
`default_nettype none

module w2r_band_sel (
    input  wire logic                                      aclk,
    input  wire w2r_pkg::pipe_ld_t                         ld,
    input  wire logic [w2r_pkg::WL_W-1:0]                  wavelength,
    output w2r_pkg::lane_in_t [w2r_pkg::NCHAN-1:0]         sel_o
);

    w2r_pkg::lane_in_t [w2r_pkg::NCHAN-1:0] sel_next;
    w2r_pkg::lane_in_t [w2r_pkg::NCHAN-1:0] sel_reg;

    // priority search per channel, lowest band index wins
    always_comb begin
        w2r_pkg::band_t bd;
        logic [w2r_pkg::WL_W-1:0] diff;
        for (int c = 0; c < w2r_pkg::NCHAN; c++) begin
            sel_next[c] = '0;
            for (int b = w2r_pkg::NBANDS - 1; b >= 0; b--) begin
                if (w2r_pkg::BANDS[b].chan == w2r_pkg::CHAN_W'(c) &&
                    wavelength >= {w2r_pkg::BANDS[b].lo_nm, 4'b0000} &&
                    wavelength <  {w2r_pkg::BANDS[b].hi_nm, 4'b0000}) begin
                    sel_next[c].hit  = 1'b1;
                    sel_next[c].band = w2r_pkg::BAND_W'(b);
                end
            end
            bd   = w2r_pkg::band_of(sel_next[c].band);
            diff = wavelength - {bd.base_nm, 4'b0000};
            sel_next[c].d = diff[w2r_pkg::D_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld.ld1) begin
            sel_reg <= sel_next;
        end
    end

    assign sel_o = sel_reg;

endmodule

`default_nettype wire

>>> design/w2r_lane.sv
// one color channel: quadratic evaluation, scaling by reciprocal and saturation
`timescale 1ns / 1ps
`default_nettype none

module w2r_lane (
    input  wire logic                         aclk,
    input  wire w2r_pkg::pipe_ld_t            ld,
    input  wire w2r_pkg::lane_in_t            sel,
    output logic [w2r_pkg::OUT_W-1:0]         chan_o
);

    // stage 2: d^2 and c1*W*d
    logic [21:0]                   dsq_next, dsq_reg;
    logic signed [31:0]            p1_next, p1_reg;
    logic signed [19:0]            k1;
    logic [w2r_pkg::BAND_W-1:0]    band2_reg;
    logic                          hit2_reg;

    always_comb begin
        k1       = w2r_pkg::band_k1(sel.band);
        dsq_next = 22'(sel.d) * 22'(sel.d);
        p1_next  = 32'(k1) * $signed({21'b0, sel.d});
    end

    always_ff @(posedge aclk) begin
        if (ld.ld2) begin
            dsq_reg   <= dsq_next;
            p1_reg    <= p1_next;
            band2_reg <= sel.band;
            hit2_reg  <= sel.hit;
        end
    end

    // stage 3: numerator N = c0*W^2 + c1*W*d + c2*d^2
    w2r_pkg::band_t                bd3;
    logic signed [8:0]             c2;
    logic signed [31:0]            p2;
    logic signed [32:0]            n_next, n_reg;
    logic [w2r_pkg::BAND_W-1:0]    band3_reg;
    logic                          hit3_reg;

    always_comb begin
        bd3    = w2r_pkg::band_of(band2_reg);
        c2     = bd3.c2;
        p2     = 32'(c2) * $signed({10'b0, dsq_reg});
        n_next = w2r_pkg::band_k0(band2_reg) + 33'(p1_reg) + 33'(p2);
    end

    always_ff @(posedge aclk) begin
        if (ld.ld3) begin
            n_reg     <= n_next;
            band3_reg <= band2_reg;
            hit3_reg  <= hit2_reg;
        end
    end

    // stage 4: scaled numerator with rounding offset, zero flag
    logic [34:0]                   z_next, z_reg;
    logic                          zero_next, zero4_reg;
    logic [w2r_pkg::BAND_W-1:0]    band4_reg;

    always_comb begin
        zero_next = !hit3_reg || n_reg[32] || (n_reg == '0);
        z_next    = {n_reg[31:0], 3'b000} + 35'(w2r_pkg::band_k25(band3_reg));
    end

    always_ff @(posedge aclk) begin
        if (ld.ld4) begin
            z_reg     <= z_next;
            zero4_reg <= zero_next;
            band4_reg <= band3_reg;
        end
    end

    // stage 5: quotient estimate by reciprocal, saturation check
    logic [19:0]                   den5;
    logic [47:0]                   prod;
    logic                          sat_next, sat5_reg, zero5_reg;
    logic [w2r_pkg::OUT_W-1:0]     q0_next, q0_5_reg;
    logic [31:0]                   zlo5_reg;
    logic [w2r_pkg::BAND_W-1:0]    band5_reg;

    always_comb begin
        den5     = w2r_pkg::band_den(band4_reg);
        sat_next = z_reg >= {3'b000, den5, 12'b0};
        prod     = 48'(z_reg[31:8]) * 48'(w2r_pkg::band_recip(band4_reg));
        q0_next  = prod[39:28];
    end

    always_ff @(posedge aclk) begin
        if (ld.ld5) begin
            q0_5_reg  <= q0_next;
            sat5_reg  <= sat_next;
            zero5_reg <= zero4_reg;
            zlo5_reg  <= z_reg[31:0];
            band5_reg <= band4_reg;
        end
    end

    // stage 6: back-multiply the estimate
    logic [31:0]                   qd_next, qd_reg;
    logic [w2r_pkg::OUT_W-1:0]     q0_6_reg;
    logic                          sat6_reg, zero6_reg;
    logic [31:0]                   zlo6_reg;
    logic [w2r_pkg::BAND_W-1:0]    band6_reg;

    always_comb begin
        qd_next = 32'(q0_5_reg) * 32'(w2r_pkg::band_den(band5_reg));
    end

    always_ff @(posedge aclk) begin
        if (ld.ld6) begin
            qd_reg    <= qd_next;
            q0_6_reg  <= q0_5_reg;
            sat6_reg  <= sat5_reg;
            zero6_reg <= zero5_reg;
            zlo6_reg  <= zlo5_reg;
            band6_reg <= band5_reg;
        end
    end

    // stage 7: correct estimate by one if remainder reaches the divisor
    logic [31:0]                   rem;
    logic [w2r_pkg::OUT_W-1:0]     qf;
    logic [w2r_pkg::OUT_W-1:0]     val_next, val_reg;

    always_comb begin
        rem = zlo6_reg - qd_reg;
        if (rem >= {12'b0, w2r_pkg::band_den(band6_reg)}) begin
            qf = q0_6_reg + 12'd1;
        end else begin
            qf = q0_6_reg;
        end
        if (zero6_reg) begin
            val_next = '0;
        end else if (sat6_reg) begin
            val_next = w2r_pkg::OUT_MAX;
        end else begin
            val_next = qf;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld.ld7) begin
            val_reg <= val_next;
        end
    end

    assign chan_o = val_reg;

endmodule

`default_nettype wire

>>> design/wavelength_to_rgb_unit.sv
// Wavelength to rgb unit: top level with pipeline control and output register.
// Throughput: one word per cycle unless the output stalls on m_ready;
// seven register stages, none more than one multiply deep.
// Each stage advances when its successor is empty or moving, so bubbles close up.
// Reset (synchronous, active low) clears the valid bits only; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module wavelength_to_rgb_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [w2r_pkg::WL_W-1:0]      s_wavelength,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [w2r_pkg::OUT_W-1:0]          m_red,
    output logic [w2r_pkg::OUT_W-1:0]          m_green,
    output logic [w2r_pkg::OUT_W-1:0]          m_blue
);

    w2r_pkg::pipe_ld_t                        ld;
    logic [5:0]                               vld_next, vld_reg;
    logic                                     m_valid_next, m_valid_reg;
    w2r_pkg::lane_in_t [w2r_pkg::NCHAN-1:0]   sel;
    logic [w2r_pkg::OUT_W-1:0]                chan_val [w2r_pkg::NCHAN];

    // load strobes, from the output register back to the input
    always_comb begin
        ld.ld7 = !m_valid_reg || m_ready;
        ld.ld6 = !vld_reg[5] || ld.ld7;
        ld.ld5 = !vld_reg[4] || ld.ld6;
        ld.ld4 = !vld_reg[3] || ld.ld5;
        ld.ld3 = !vld_reg[2] || ld.ld4;
        ld.ld2 = !vld_reg[1] || ld.ld3;
        ld.ld1 = !vld_reg[0] || ld.ld2;
    end

    // valid bits follow the data
    always_comb begin
        vld_next     = vld_reg;
        m_valid_next = m_valid_reg;
        if (ld.ld1) vld_next[0] = s_valid;
        if (ld.ld2) vld_next[1] = vld_reg[0];
        if (ld.ld3) vld_next[2] = vld_reg[1];
        if (ld.ld4) vld_next[3] = vld_reg[2];
        if (ld.ld5) vld_next[4] = vld_reg[3];
        if (ld.ld6) vld_next[5] = vld_reg[4];
        if (ld.ld7) m_valid_next = vld_reg[5];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // band lookup
    w2r_band_sel u_band_sel (
        .aclk       (aclk),
        .ld         (ld),
        .wavelength (s_wavelength),
        .sel_o      (sel)
    );

    // one arithmetic lane per color
    for (genvar c = 0; c < w2r_pkg::NCHAN; c++) begin : g_lane
        w2r_lane u_lane (
            .aclk   (aclk),
            .ld     (ld),
            .sel    (sel[c]),
            .chan_o (chan_val[c])
        );
    end

    assign s_ready = ld.ld1;
    assign m_valid = m_valid_reg;
    assign m_red   = chan_val[w2r_pkg::CH_RED];
    assign m_green = chan_val[w2r_pkg::CH_GREEN];
    assign m_blue  = chan_val[w2r_pkg::CH_BLUE];

endmodule

`default_nettype wire
